### hw/rtl/majority_vote_flow_sketch_top_defines.svh
// assertion macros used by the port-level checker
`ifndef MAJORITY_VOTE_FLOW_SKETCH_TOP_DEFINES_SVH
`define MAJORITY_VOTE_FLOW_SKETCH_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define MV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mvs_pkg.sv
// shared types and constants for the flow sketch
package mvs_pkg;
   localparam int NUM_ROWS = 4;
   localparam int BUCKETS_PER_ROW = 1024;
   localparam int IDX_W = $clog2(BUCKETS_PER_ROW);
   localparam int IN_IDX_W = 10;
   localparam int CNT_W = 32;
   localparam int AMT_W = 16;
   localparam int QDEPTH = 2;
   localparam logic [CNT_W-1:0] SAT = '1;

   typedef enum logic {KIND_INSERT = 1'b0, KIND_QUERY = 1'b1} kind_type;

   typedef struct packed {
      logic [31:0] sip;
      logic [31:0] dip;
      logic [31:0] ports;
      logic [7:0] proto;
   } key_type;

   typedef struct packed {
      kind_type kind;
      key_type key;
      logic [AMT_W-1:0] amount;
      logic [NUM_ROWS-1:0][IDX_W-1:0] idx;
   } op_type;

   typedef struct packed {
      key_type key;
      logic [CNT_W-1:0] total;
      logic [CNT_W-1:0] vote;
   } bucket_type;

   function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? SAT : s[CNT_W-1:0];
   endfunction
endpackage

### hw/rtl/mvs_front.sv
// front part: takes requests and packs them into the operation queue
module mvs_front (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  mvs_pkg::op_type op_in,
   output logic q_valid,
   input  logic q_take,
   output mvs_pkg::op_type q_op
);
   localparam int PW = $clog2(mvs_pkg::QDEPTH);
   mvs_pkg::op_type mem_ff [mvs_pkg::QDEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [PW:0] cnt_ff, cnt_in;
   logic wr, rd;

   assign full = (cnt_ff == (PW+1)'(mvs_pkg::QDEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_op = mem_ff[rp_ff];
   assign wr = push && !full;
   assign rd = q_take && q_valid;
   always_comb begin
      cnt_in = cnt_ff;
      if (wr && !rd) cnt_in = cnt_ff + 1'b1;
      else if (rd && !wr) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end
   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= op_in;
   end
endmodule

### hw/rtl/mvs_row.sv
// one sketch row: bucket memory with read-modify-write and row estimate
module mvs_row (
   input  logic clock,
   input  logic reset,
   input  logic clr_we,
   input  logic [mvs_pkg::IDX_W-1:0] clr_addr,
   input  logic rd_en,
   input  logic [mvs_pkg::IDX_W-1:0] rd_addr,
   input  logic wb_en,
   input  logic [mvs_pkg::IDX_W-1:0] wb_addr,
   input  mvs_pkg::key_type key,
   input  logic [mvs_pkg::AMT_W-1:0] amount,
   output mvs_pkg::bucket_type wb_data,
   output logic [mvs_pkg::CNT_W-1:0] est
);
   mvs_pkg::bucket_type mem [mvs_pkg::BUCKETS_PER_ROW];
   mvs_pkg::bucket_type rd_ff;
   logic hit;
   logic [mvs_pkg::CNT_W-1:0] amt;
   logic [mvs_pkg::CNT_W:0] sum;

   always_ff @(posedge clock) begin
      if (clr_we) mem[clr_addr] <= '0;
      else if (wb_en) mem[wb_addr] <= wb_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   assign hit = (rd_ff.key == key);
   assign amt = mvs_pkg::CNT_W'(amount);
   always_comb begin
      wb_data = rd_ff;
      wb_data.total = mvs_pkg::sat_add(rd_ff.total, amt);
      if (hit) wb_data.vote = mvs_pkg::sat_add(rd_ff.vote, amt);
      else if (amt > rd_ff.vote) begin
         wb_data.vote = amt - rd_ff.vote;
         wb_data.key = key;
      end else wb_data.vote = rd_ff.vote - amt;
      sum = {1'b0, rd_ff.total} + (hit ? {1'b0, rd_ff.vote} : -{1'b0, rd_ff.vote});
      if (!hit && rd_ff.vote > rd_ff.total) est = '0;
      else est = sum[mvs_pkg::CNT_W:1];
   end
   logic unused;
   assign unused = reset;
endmodule

### hw/rtl/mvs_back.sv
// back part: clears the rows after reset, then runs each operation through a read state and an execute state
module mvs_back (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_take,
   input  mvs_pkg::op_type q_op,
   output logic rsp_valid,
   output logic [mvs_pkg::CNT_W-1:0] rsp_est,
   input  logic rsp_room
);
   typedef enum logic [1:0] {ST_CLEAR, ST_READ, ST_EXEC} state_type;
   state_type state_ff;
   logic [mvs_pkg::IDX_W-1:0] clr_ff;
   mvs_pkg::op_type op_ff;
   logic [mvs_pkg::NUM_ROWS-1:0][mvs_pkg::CNT_W-1:0] est;
   logic [mvs_pkg::CNT_W-1:0] best;
   logic exec_wb;

   assign q_take = (state_ff == ST_READ) && q_valid;
   assign exec_wb = (state_ff == ST_EXEC) && op_ff.kind == mvs_pkg::KIND_INSERT;

   for (genvar r = 0; r < mvs_pkg::NUM_ROWS; r++) begin : g_row
      mvs_pkg::bucket_type wbd;
      mvs_row u_row (
         .clock(clock), .reset(reset),
         .clr_we(state_ff == ST_CLEAR), .clr_addr(clr_ff),
         .rd_en(q_take), .rd_addr(q_op.idx[r]),
         .wb_en(exec_wb), .wb_addr(op_ff.idx[r]),
         .key(op_ff.key), .amount(op_ff.amount),
         .wb_data(wbd), .est(est[r])
      );
   end

   always_comb begin
      best = mvs_pkg::SAT;
      for (int r = 0; r < mvs_pkg::NUM_ROWS; r++) if (est[r] < best) best = est[r];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == mvs_pkg::IDX_W'(mvs_pkg::BUCKETS_PER_ROW - 1))
                  state_ff <= ST_READ;
            end
            ST_READ: if (q_take) begin
               op_ff <= q_op;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (op_ff.kind == mvs_pkg::KIND_INSERT) state_ff <= ST_READ;
               else if (rsp_room) begin
                  rsp_valid <= 1'b1;
                  rsp_est <= best;
                  state_ff <= ST_READ;
               end
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end
endmodule

### hw/rtl/mvs_outq.sv
// result queue that decouples the back part from the receiver
module mvs_outq (
   input  logic clock,
   input  logic reset,
   input  logic wr,
   input  logic [mvs_pkg::CNT_W-1:0] din,
   output logic room,
   output logic empty,
   input  logic pop,
   output logic [mvs_pkg::CNT_W-1:0] dout
);
   logic [1:0][mvs_pkg::CNT_W-1:0] mem_ff;
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic rd;
   // room only when two free so one in-flight write always fits
   assign room = (cnt_ff == 2'd0);
   assign empty = (cnt_ff == 2'd0);
   assign dout = mem_ff[rp_ff];
   assign rd = pop && !empty;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= din;
   end
endmodule

### hw/rtl/majority_vote_flow_sketch_top.sv
// top level of the majority-vote flow sketch
// Usage: requests enter through req_push/req_full; each carries kind
// (insert or query), the flow 5-tuple, an amount and one bucket index per
// row. Inserts give no response; a query gives one estimate on rsp_estimate,
// read through rsp_empty/rsp_pop like a queue.
// Timing: with the back part idle, a request is read from the buckets in the
// cycle after it is accepted; a query's estimate then passes the back part's
// response register and the result queue. Flow: the back part reads a new
// request only after the last one's read-modify-write of each row is done.
// Reset: synchronous, active high; afterwards a clearing pass zeroes all
// 1024 buckets of every row, one bucket per row per cycle. Requests are
// queued meanwhile but not executed until it finishes.
// Stall: while a query result waits unread, the back part holds the next
// query; inserts still wait behind it in order. A two-entry request queue
// fills and raises req_full.
module majority_vote_flow_sketch_top (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_kind,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [7:0] req_proto,
   input  logic [15:0] req_amount,
   input  logic [9:0] req_row_index_0,
   input  logic [9:0] req_row_index_1,
   input  logic [9:0] req_row_index_2,
   input  logic [9:0] req_row_index_3,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [31:0] rsp_estimate
);
   mvs_pkg::op_type op_in, q_op;
   logic q_valid, q_take, bk_valid, room;
   logic [mvs_pkg::CNT_W-1:0] bk_est;
   logic [3:0][9:0] raw;

   assign raw = {req_row_index_3, req_row_index_2, req_row_index_1, req_row_index_0};
   always_comb begin
      op_in.kind = mvs_pkg::kind_type'(req_kind);
      op_in.key.sip = req_src_ip;
      op_in.key.dip = req_dst_ip;
      op_in.key.ports = {req_src_port, req_dst_port};
      op_in.key.proto = req_proto;
      op_in.amount = req_amount;
      for (int r = 0; r < mvs_pkg::NUM_ROWS; r++) op_in.idx[r] = raw[r][mvs_pkg::IDX_W-1:0];
   end

   mvs_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full), .op_in(op_in),
      .q_valid(q_valid), .q_take(q_take), .q_op(q_op)
   );
   mvs_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take), .q_op(q_op),
      .rsp_valid(bk_valid), .rsp_est(bk_est), .rsp_room(room)
   );
   mvs_outq u_outq (
      .clock(clock), .reset(reset), .wr(bk_valid), .din(bk_est), .room(room),
      .empty(rsp_empty), .pop(rsp_pop), .dout(rsp_estimate)
   );
endmodule

### hw/rtl/mvs_checker.sv
// port-level checker for the flow sketch top level
`include "majority_vote_flow_sketch_top_defines.svh"
module mvs_checker (
   input logic clock,
   input logic reset,
   input logic req_push,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input logic [31:0] rsp_estimate
);
   `MV_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_estimate), "result changed while waiting")
   `MV_ASSERT_IMP(a_rst_empty, clock, 1'b0, $past(reset), rsp_empty, "result present right after reset")
   `MV_ASSERT_NEXT(a_no_push_no_full, clock, reset, !req_push && !req_full, !req_full, "queue filled with no request")
endmodule

bind majority_vote_flow_sketch_top mvs_checker u_mvs_checker (
   .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
   .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_estimate(rsp_estimate)
);

### tb/majority_vote_flow_sketch_top_tb.sv
// self-checking testbench for the majority-vote flow sketch top level
module majority_vote_flow_sketch_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SKETCH_ROWS = 4;
   localparam int SKETCH_COLS = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef struct {
      mvs_pkg::kind_type kind;
      logic [31:0] sip;
      logic [31:0] dip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0] proto;
      logic [15:0] amount;
      logic [9:0] idx [SKETCH_ROWS];
   } flow_req_type;

   class estimate_scoreboard;
      logic [31:0] key_sip [SKETCH_ROWS*SKETCH_COLS];
      logic [31:0] key_dip [SKETCH_ROWS*SKETCH_COLS];
      logic [31:0] key_ports [SKETCH_ROWS*SKETCH_COLS];
      logic [7:0] key_proto [SKETCH_ROWS*SKETCH_COLS];
      logic [31:0] total [SKETCH_ROWS*SKETCH_COLS];
      logic [31:0] vote [SKETCH_ROWS*SKETCH_COLS];
      logic [31:0] pending_estimates [$];
      int errors;

      function new();
         foreach (total[i]) begin
            key_sip[i] = '0; key_dip[i] = '0; key_ports[i] = '0; key_proto[i] = '0;
            total[i] = '0; vote[i] = '0;
         end
         errors = 0;
      endfunction

      function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
         logic [32:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[32] ? ALL_ONES : s[31:0];
      endfunction

      function void note_request(flow_req_type r);
         logic [31:0] ports;
         logic [31:0] best;
         logic [32:0] e;
         int b;
         bit hit;
         ports = {r.sport, r.dport};
         best = ALL_ONES;
         for (int row = 0; row < SKETCH_ROWS; row++) begin
            b = row * SKETCH_COLS + (r.idx[row] % SKETCH_COLS);
            hit = key_sip[b] == r.sip && key_dip[b] == r.dip &&
                  key_ports[b] == ports && key_proto[b] == r.proto;
            if (r.kind == mvs_pkg::KIND_INSERT) begin
               total[b] = add_sat(total[b], {16'h0, r.amount});
               if (hit) vote[b] = add_sat(vote[b], {16'h0, r.amount});
               else if ({16'h0, r.amount} > vote[b]) begin
                  vote[b] = {16'h0, r.amount} - vote[b];
                  key_sip[b] = r.sip; key_dip[b] = r.dip;
                  key_ports[b] = ports; key_proto[b] = r.proto;
               end else vote[b] = vote[b] - {16'h0, r.amount};
            end else begin
               if (hit) e = ({1'b0, total[b]} + {1'b0, vote[b]}) >> 1;
               else if (total[b] >= vote[b]) e = {1'b0, total[b] - vote[b]} >> 1;
               else e = '0;
               if (e[31:0] < best) best = e[31:0];
            end
         end
         if (r.kind == mvs_pkg::KIND_QUERY) pending_estimates.push_back(best);
      endfunction

      function void check_estimate(logic [31:0] got);
         logic [31:0] want;
         if (pending_estimates.size() == 0) begin
            $display("%0t: unexpected estimate %0d", $time, got);
            errors++;
            return;
         end
         want = pending_estimates.pop_front();
         if (got !== want) begin
            $display("%0t: estimate mismatch expected %0d actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic req_kind = 0;
   logic [31:0] req_src_ip = '0;
   logic [31:0] req_dst_ip = '0;
   logic [15:0] req_src_port = '0;
   logic [15:0] req_dst_port = '0;
   logic [7:0] req_proto = '0;
   logic [15:0] req_amount = '0;
   logic [9:0] req_row_index_0 = '0;
   logic [9:0] req_row_index_1 = '0;
   logic [9:0] req_row_index_2 = '0;
   logic [9:0] req_row_index_3 = '0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic [31:0] rsp_estimate;

   estimate_scoreboard sb = new();
   int cycle_count = 0;
   bit hold_off = 0;
   bit stim_done = 0;

   // small pool of flows and buckets so keys collide and votes swing
   logic [31:0] pool_sip [4];
   logic [31:0] pool_dip [4];

   majority_vote_flow_sketch_top u_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // push stays high between back-to-back requests
   task automatic send(flow_req_type r);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1;
      req_kind <= r.kind;
      req_src_ip <= r.sip; req_dst_ip <= r.dip;
      req_src_port <= r.sport; req_dst_port <= r.dport;
      req_proto <= r.proto; req_amount <= r.amount;
      req_row_index_0 <= r.idx[0]; req_row_index_1 <= r.idx[1];
      req_row_index_2 <= r.idx[2]; req_row_index_3 <= r.idx[3];
      do @(posedge clock); while (req_full);
      sb.note_request(r);
   endtask

   function automatic flow_req_type make_flow(mvs_pkg::kind_type k, int f, logic [15:0] amt,
                                              int span);
      flow_req_type r;
      r.kind = k;
      r.sip = pool_sip[f]; r.dip = pool_dip[f];
      r.sport = 16'(f * 7); r.dport = 16'(80 + f); r.proto = 8'(6 + f);
      r.amount = amt;
      for (int i = 0; i < SKETCH_ROWS; i++) r.idx[i] = 10'($urandom_range(0, span));
      return r;
   endfunction

   function automatic flow_req_type make_noise();
      flow_req_type r;
      r.kind = mvs_pkg::kind_type'($urandom_range(0, 1));
      r.sip = $urandom; r.dip = $urandom;
      r.sport = 16'($urandom); r.dport = 16'($urandom); r.proto = 8'($urandom);
      r.amount = 16'($urandom);
      for (int i = 0; i < SKETCH_ROWS; i++) r.idx[i] = 10'($urandom);
      return r;
   endfunction

   // receiver
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         wait_cycles = $urandom_range(0, 4);
         if ($urandom_range(0, 3) == 0) wait_cycles = 0;
         if (hold_off) begin
            // long stall so the request queue fills up
            rsp_pop <= 0;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end else if (wait_cycles > 0) begin
            rsp_pop <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_pop <= 1;
         do @(posedge clock); while (rsp_empty);
         sb.check_estimate(rsp_estimate);
      end
   end

   initial begin
      flow_req_type r;
      int f;
      for (int i = 0; i < 4; i++) begin
         pool_sip[i] = $urandom; pool_dip[i] = $urandom;
      end
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: zero key, all-ones key, index extremes, maximum amounts
      r = make_noise();
      r.kind = mvs_pkg::KIND_QUERY; r.sip = '0; r.dip = '0; r.sport = '0; r.dport = '0;
      r.proto = '0; r.amount = '0;
      foreach (r.idx[i]) r.idx[i] = '0;
      send(r);
      r.kind = mvs_pkg::KIND_INSERT; r.amount = 16'hFFFF; send(r);
      r.kind = mvs_pkg::KIND_QUERY; send(r);
      r.kind = mvs_pkg::KIND_INSERT; r.sip = ALL_ONES; r.dip = ALL_ONES; r.sport = '1;
      r.dport = '1; r.proto = '1; r.amount = 16'hFFFF;
      foreach (r.idx[i]) r.idx[i] = '1;
      send(r);
      r.amount = 16'h1; send(r);
      r.kind = mvs_pkg::KIND_QUERY; send(r);
      r.sip = 32'h1234; r.kind = mvs_pkg::KIND_INSERT; r.amount = 16'hFFFE; send(r);
      r.kind = mvs_pkg::KIND_QUERY; send(r);
      // mismatch with an amount above the vote replaces the candidate
      r.sip = 32'h5555; r.kind = mvs_pkg::KIND_INSERT; r.amount = 16'hFFFE; send(r);
      r.kind = mvs_pkg::KIND_QUERY; send(r);
      r.sip = 32'h5555; r.amount = 16'h1234; send(r);
      // heavy load: hammer one bucket set with max amounts
      for (int i = 0; i < 12; i++) begin
         r = make_flow(mvs_pkg::KIND_INSERT, 0, 16'hFFFF, 0);
         send(r);
      end
      r = make_flow(mvs_pkg::KIND_QUERY, 0, 16'h0, 0); send(r);
      r = make_flow(mvs_pkg::KIND_QUERY, 1, 16'h0, 0); send(r);

      // random part
      for (int n = 0; n < 1200; n++) begin
         if (n == 300) hold_off = 1;
         if (n == 700) begin
            req_push <= 0;
            wait (sb.pending_estimates.size() == 0);
            repeat (10) @(posedge clock);
         end
         f = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0: r = make_noise();
            1, 2, 3: r = make_flow(mvs_pkg::KIND_QUERY, f, 16'($urandom), 7);
            default: r = make_flow(mvs_pkg::KIND_INSERT, f, 16'($urandom_range(0, 300)), 7);
         endcase
         if ($urandom_range(0, 40) == 0) r.amount = 16'hFFFF;
         send(r);
      end
      req_push <= 0;

      wait (sb.pending_estimates.size() == 0);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/mvs_pkg.sv
hw/rtl/mvs_front.sv
hw/rtl/mvs_row.sv
hw/rtl/mvs_back.sv
hw/rtl/mvs_outq.sv
hw/rtl/majority_vote_flow_sketch_top.sv
hw/rtl/mvs_checker.sv
tb/majority_vote_flow_sketch_top_tb.sv
